>>> hw/rtl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg: shared types and constants of the orbit camera position core
// Wrap thresholds, angle limits, register and opcode names, CORDIC table.
// ----------------------------------------------------------------------------
package ocp_pkg;

	// event opcodes
	localparam logic [1:0] OP_MOVE   = 2'd0;
	localparam logic [1:0] OP_WHEEL  = 2'd1;
	localparam logic [1:0] OP_RESYNC = 2'd2;
	localparam logic [1:0] OP_OTHER  = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_RADIUS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_AZIMUTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_POLAR   = 3'd6;

	// cursor wrap window, Q0.16
	localparam logic [15:0] WRAP_LOW  = 16'd6554;
	localparam logic [15:0] WRAP_HIGH = 16'd58982;

	// polar clamp, Q0.16 turns
	localparam logic signed [26:0] POLAR_MIN = 27'sd33;
	localparam logic signed [26:0] POLAR_MAX = 27'sd32735;

	// position saturation, Q12.4
	localparam logic signed [16:0] POS_MIN = -17'sd65536;
	localparam logic signed [16:0] POS_MAX = 17'sd65535;

	// CORDIC: Q2.30 datapath, Q0.32 angle, 1/K start value
	localparam int unsigned CORDIC_W = 34;
	localparam int unsigned ATAN_ENTRIES = 24;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

	typedef struct packed {
		logic               done;
		logic signed [32:0] sin_v;
		logic signed [32:0] cos_v;
	} cordic_res_t;

	// atan(2^-i) in Q0.32 turns
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051D;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// returns {wrapped, coordinate}
	function automatic logic [16:0] wrap_coord(input logic [15:0] v);
		logic [16:0] r;
		if (v < WRAP_LOW) begin
			r = {1'b1, WRAP_HIGH};
		end else if (v > WRAP_HIGH) begin
			r = {1'b1, WRAP_LOW};
		end else begin
			r = {1'b0, v};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/ocp_cordic.sv
// ----------------------------------------------------------------------------
// ocp_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle
// Q0.16 turn angle in, Q2.30 sine and cosine out with a done pulse.
// ----------------------------------------------------------------------------
module ocp_cordic #(
	parameter int STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         angle,
	output ocp_pkg::cordic_res_t res
);

	localparam int NSTEP = (STEPS < ocp_pkg::ATAN_ENTRIES) ? STEPS : ocp_pkg::ATAN_ENTRIES;
	localparam int CW    = $clog2(NSTEP);
	localparam int W     = ocp_pkg::CORDIC_W;

	logic signed [W-1:0] x_q, y_q, z_q;
	logic                flip_q, busy_q, done_q;
	logic [CW-1:0]       cnt_q;

	logic                flip_in;
	logic signed [W-1:0] z_in, xs, ys, atan_v, nx, ny, nz;

	// half-turn fold for the left half plane
	assign flip_in = angle[15] ^ angle[14];
	assign z_in    = W'($signed({angle[15] ^ flip_in, angle[14:0], 16'h0000}));

	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atan_v = $signed({2'b00, ocp_pkg::atan_turn(5'(cnt_q))});

	always_comb begin
		if (!z_q[W-1]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - atan_v;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + atan_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ocp_pkg::CORDIC_X0;
			y_q    <= '0;
			z_q    <= z_in;
			flip_q <= flip_in;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	assign res.done  = done_q;
	assign res.sin_v = flip_q ? 33'(-y_q) : 33'(y_q);
	assign res.cos_v = flip_q ? 33'(-x_q) : 33'(x_q);

endmodule

>>> hw/rtl/orbit_camera_position_core.sv
// ----------------------------------------------------------------------------
// orbit_camera_position_core: orbit camera steered by cursor and wheel
// Updates azimuth, polar angle and radius per event and returns the camera
// position on the sphere together with the wrapped cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one event beat: op, cursor,
//   wheel notches. Output channel (out_valid/out_ready) returns one result
//   beat per event: handled flag, wrap flag, wrapped cursor, position.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
//   used while no event is in flight; start_* writes also load the state.
//   Events are handled one at a time by the sequencer, whose run time is
//   set by the single CORDIC unit, run once for the polar and once for the
//   azimuth angle, plus the single 33x33 multiplier used for gains and the
//   four products.
//   in_ready is high only while the sequencer is idle.
//   The result beat sits in its own output register, so the next event is
//   taken while it waits; if the receiver still stalls when the following
//   result is done, the sequencer holds in its final step until out_ready.
//   Reset: registers return to defaults, state loads the start values,
//   the previous cursor goes to mid-window, no beats pending.
// ----------------------------------------------------------------------------
module orbit_camera_position_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [ocp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                        cfg_data,
	// event input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         op,
	input  logic [15:0]                        cursor_x,
	input  logic [15:0]                        cursor_y,
	input  logic signed [7:0]                  wheel_notches,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               handled,
	output logic                               cursor_wrapped,
	output logic [15:0]                        cursor_x_out,
	output logic [15:0]                        cursor_y_out,
	output logic signed [16:0]                 pos_x,
	output logic signed [16:0]                 pos_y,
	output logic signed [16:0]                 pos_z
);

	// sequencer steps
	localparam logic [3:0] S_IDLE  = 4'd0;   // wait for an event
	localparam logic [3:0] S_GAIN1 = 4'd1;   // dx*gain or notches*gain
	localparam logic [3:0] S_GAIN2 = 4'd2;   // azimuth/radius update or resync, dy*gain
	localparam logic [3:0] S_POLAR = 4'd3;   // polar and previous-cursor update
	localparam logic [3:0] S_CORP  = 4'd4;   // launch CORDIC on polar
	localparam logic [3:0] S_WAITP = 4'd5;
	localparam logic [3:0] S_CORA  = 4'd6;   // launch CORDIC on azimuth
	localparam logic [3:0] S_WAITA = 4'd7;
	localparam logic [3:0] S_MULT  = 4'd8;   // r*sin(p)
	localparam logic [3:0] S_MULY  = 4'd9;   // r*cos(p)
	localparam logic [3:0] S_MULX  = 4'd10;  // t*cos(a)
	localparam logic [3:0] S_MULZ  = 4'd11;  // t*sin(a)
	localparam logic [3:0] S_FIN   = 4'd12;  // hand result to output register

	logic [3:0] state_q;

	// configuration registers
	logic [15:0]        mouse_gain_q, radius_min_q, radius_max_q;
	logic signed [15:0] wheel_gain_q;

	// camera state
	logic [15:0] azimuth_q, polar_q, radius_q, prev_x_q, prev_y_q;

	// current event
	logic [1:0]        op_q;
	logic [15:0]       cx_q, cy_q;
	logic              wrap_q;
	logic signed [7:0] notch_q;

	// datapath
	logic signed [65:0] prod_q;
	logic signed [32:0] t_q, sin_p_q, cos_p_q, sin_a_q, cos_a_q;
	logic signed [16:0] px_q, py_q;

	// output register
	logic               out_valid_q, out_handled_q, out_wrap_q;
	logic [15:0]        out_cx_q, out_cy_q;
	logic signed [16:0] out_px_q, out_py_q, out_pz_q;

	// cursor wrap: x first, y only when x stayed inside
	logic [16:0] wx, wy;
	logic [15:0] cx_w, cy_w;
	logic        wrapped;
	logic        accept;

	assign wx      = ocp_pkg::wrap_coord(cursor_x);
	assign wy      = ocp_pkg::wrap_coord(cursor_y);
	assign cx_w    = wx[15:0];
	assign cy_w    = wx[16] ? cursor_y : wy[15:0];
	assign wrapped = wx[16] | wy[16];
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [16:0] dx, dy;

	assign dx    = $signed({1'b0, cx_q}) - $signed({1'b0, prev_x_q});
	assign dy    = $signed({1'b0, cy_q}) - $signed({1'b0, prev_y_q});
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_GAIN1: begin
				if (op_q == ocp_pkg::OP_WHEEL) begin
					mul_a = 33'(notch_q);
					mul_b = 33'(wheel_gain_q);
				end else begin
					mul_a = 33'(dx);
					mul_b = $signed({17'b0, mouse_gain_q});
				end
			end
			S_GAIN2: begin
				mul_a = 33'(dy);
				mul_b = $signed({17'b0, mouse_gain_q});
			end
			S_MULT: begin
				mul_a = $signed({17'b0, radius_q});
				mul_b = sin_p_q;
			end
			S_MULY: begin
				mul_a = $signed({17'b0, radius_q});
				mul_b = cos_p_q;
			end
			S_MULX: begin
				mul_a = t_q;
				mul_b = cos_a_q;
			end
			S_MULZ: begin
				mul_a = t_q;
				mul_b = sin_a_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// gain scaling to Q0.16, round half up
	logic signed [33:0] ang_sum;
	logic signed [25:0] ang_step;
	logic signed [26:0] polar_sum;
	logic [15:0]        polar_next;

	assign ang_sum   = prod_q[33:0] + 34'sd128;
	assign ang_step  = ang_sum[33:8];
	assign polar_sum = $signed({11'b0, polar_q}) + {ang_step[25], ang_step};

	always_comb begin
		if (polar_sum > ocp_pkg::POLAR_MAX) begin
			polar_next = ocp_pkg::POLAR_MAX[15:0];
		end else if (polar_sum < ocp_pkg::POLAR_MIN) begin
			polar_next = ocp_pkg::POLAR_MIN[15:0];
		end else begin
			polar_next = polar_sum[15:0];
		end
	end

	// radius: clamp to max, then min (min wins on conflict)
	logic signed [25:0] rad_sum;
	logic [15:0]        radius_next;

	assign rad_sum = $signed({10'b0, radius_q}) + {{2{prod_q[23]}}, prod_q[23:0]};

	always_comb begin
		if (rad_sum < $signed({10'b0, radius_min_q}) || radius_max_q < radius_min_q) begin
			radius_next = radius_min_q;
		end else if (rad_sum > $signed({10'b0, radius_max_q})) begin
			radius_next = radius_max_q;
		end else begin
			radius_next = rad_sum[15:0];
		end
	end

	// product rounding and saturation to Q12.4
	function automatic logic signed [16:0] round_sat(input logic signed [65:0] v,
			input int unsigned sh);
		logic signed [65:0] bias, r;
		bias = 66'sd1 <<< (sh - 1);
		r    = (v + bias) >>> sh;
		if (r > 66'(ocp_pkg::POS_MAX)) begin
			return ocp_pkg::POS_MAX;
		end else if (r < 66'(ocp_pkg::POS_MIN)) begin
			return ocp_pkg::POS_MIN;
		end
		return r[16:0];
	endfunction

	logic signed [65:0] t_sum;
	assign t_sum = (prod_q + 66'sd16384) >>> 15;

	// shared CORDIC
	logic                 cord_start;
	logic [15:0]          cord_angle;
	ocp_pkg::cordic_res_t cord_res;

	assign cord_start = (state_q == S_CORP) || (state_q == S_CORA);
	assign cord_angle = (state_q == S_CORP) ? polar_q : azimuth_q;

	ocp_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (cord_angle),
		.res    (cord_res)
	);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// control, configuration and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			mouse_gain_q <= 16'd256;
			wheel_gain_q <= 16'sd16;
			radius_min_q <= 16'd16;
			radius_max_q <= 16'd65535;
			radius_q     <= 16'd1600;
			azimuth_q    <= 16'd0;
			polar_q      <= 16'd16384;
			prev_x_q     <= 16'd32768;
			prev_y_q     <= 16'd32768;
		end else begin
			// a finished result refills the output register as the old beat leaves
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (wrapped) begin
							prev_x_q <= cx_w;
							prev_y_q <= cy_w;
						end
						state_q <= S_GAIN1;
					end
				end
				S_GAIN1: state_q <= S_GAIN2;
				S_GAIN2: begin
					case (op_q)
						ocp_pkg::OP_MOVE:   azimuth_q <= azimuth_q + ang_step[15:0];
						ocp_pkg::OP_WHEEL:  radius_q  <= radius_next;
						ocp_pkg::OP_RESYNC: begin
							prev_x_q <= cx_q;
							prev_y_q <= cy_q;
						end
						default: ;
					endcase
					state_q <= S_POLAR;
				end
				S_POLAR: begin
					if (op_q == ocp_pkg::OP_MOVE) begin
						polar_q  <= polar_next;
						prev_x_q <= cx_q;
						prev_y_q <= cy_q;
					end
					state_q <= S_CORP;
				end
				S_CORP:  state_q <= S_WAITP;
				S_WAITP: begin
					if (cord_res.done) begin
						state_q <= S_CORA;
					end
				end
				S_CORA:  state_q <= S_WAITA;
				S_WAITA: begin
					if (cord_res.done) begin
						state_q <= S_MULT;
					end
				end
				S_MULT:  state_q <= S_MULY;
				S_MULY:  state_q <= S_MULX;
				S_MULX:  state_q <= S_MULZ;
				S_MULZ:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_index)
					ocp_pkg::CFG_MOUSE_GAIN:    mouse_gain_q <= cfg_data;
					ocp_pkg::CFG_WHEEL_GAIN:    wheel_gain_q <= $signed(cfg_data);
					ocp_pkg::CFG_RADIUS_MIN:    radius_min_q <= cfg_data;
					ocp_pkg::CFG_RADIUS_MAX:    radius_max_q <= cfg_data;
					ocp_pkg::CFG_START_RADIUS:  radius_q     <= cfg_data;
					ocp_pkg::CFG_START_AZIMUTH: azimuth_q    <= cfg_data;
					ocp_pkg::CFG_START_POLAR:   polar_q      <= {1'b0, cfg_data[14:0]};
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= op;
					cx_q    <= cx_w;
					cy_q    <= cy_w;
					wrap_q  <= wrapped;
					notch_q <= wheel_notches;
				end
			end
			S_GAIN1, S_GAIN2, S_MULT: prod_q <= mul_p;
			S_WAITP: begin
				if (cord_res.done) begin
					sin_p_q <= cord_res.sin_v;
					cos_p_q <= cord_res.cos_v;
				end
			end
			S_WAITA: begin
				if (cord_res.done) begin
					sin_a_q <= cord_res.sin_v;
					cos_a_q <= cord_res.cos_v;
				end
			end
			S_MULY: begin
				t_q    <= t_sum[32:0];
				prod_q <= mul_p;
			end
			S_MULX: begin
				py_q   <= round_sat(prod_q, 30);
				prod_q <= mul_p;
			end
			S_MULZ: begin
				px_q   <= round_sat(prod_q, 45);
				prod_q <= mul_p;
			end
			S_FIN: begin
				if (out_free) begin
					out_handled_q <= (op_q == ocp_pkg::OP_MOVE) || (op_q == ocp_pkg::OP_WHEEL);
					out_wrap_q    <= wrap_q;
					out_cx_q      <= cx_q;
					out_cy_q      <= cy_q;
					out_px_q      <= px_q;
					out_py_q      <= py_q;
					out_pz_q      <= round_sat(prod_q, 45);
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign handled        = out_handled_q;
	assign cursor_wrapped = out_wrap_q;
	assign cursor_x_out   = out_cx_q;
	assign cursor_y_out   = out_cy_q;
	assign pos_x          = out_px_q;
	assign pos_y          = out_py_q;
	assign pos_z          = out_pz_q;

endmodule

>>> hw/rtl/ocp_checker.sv
// ----------------------------------------------------------------------------
// ocp_checker: port-level checks for the orbit camera position core
// Busy after an event, stalled result held, wrapped cursor window.
// ----------------------------------------------------------------------------
module ocp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               cursor_wrapped,
	input logic [15:0]        cursor_x_out,
	input logic [15:0]        cursor_y_out,
	input logic signed [16:0] pos_x,
	input logic signed [16:0] pos_y,
	input logic signed [16:0] pos_z
);

	// one event at a time: the beat taken makes the block busy
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(pos_z) && $stable(cursor_x_out) && $stable(cursor_y_out))
		else $error("stalled result beat changed");

	// x is always brought inside the wrap window
	a_x_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_x_out >= ocp_pkg::WRAP_LOW && cursor_x_out <= ocp_pkg::WRAP_HIGH)
		else $error("cursor_x_out outside wrap window");

	// without a wrap, y was already inside the window
	a_y_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cursor_wrapped |->
			cursor_y_out >= ocp_pkg::WRAP_LOW && cursor_y_out <= ocp_pkg::WRAP_HIGH)
		else $error("unwrapped cursor_y_out outside wrap window");

endmodule

bind orbit_camera_position_core ocp_checker u_ocp_checker (.*);
